@@ rtl/pdt_pkg.sv @@
`default_nettype none

package pdt_pkg;

  // fixed field widths
  localparam int IDX_W      = 10;
  localparam int LVL_W      = 32;
  localparam int CFG_W      = 24;
  localparam int LEN_W      = 11;
  localparam int OUT_CODE_W = 14;
  localparam int PEAK_W     = 24;

  // result queue depth, a power of two
  localparam int OUT_FIFO_DEPTH = 32;

  localparam logic signed [PEAK_W-1:0] PEAK_MAX = 24'sh7FFFFF;
  localparam logic signed [PEAK_W-1:0] PEAK_MIN = 24'sh800000;

  // register reset values
  localparam logic signed [CFG_W-1:0] OFFSET_RST  = 24'sd2097152;
  localparam logic signed [CFG_W-1:0] TRIGGER_RST = -24'sd6291;
  localparam logic [IDX_W-1:0]        PRETRIG_RST = 10'd5;
  localparam logic [LEN_W-1:0]        EVLEN_RST   = 11'd1000;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } opcode_t;

  typedef enum logic {
    RK_SAMPLE = 1'b0,
    RK_READ   = 1'b1
  } result_kind_t;

  typedef enum logic [1:0] {
    CFG_OFFSET  = 2'd0,
    CFG_TRIGGER = 2'd1,
    CFG_PRETRIG = 2'd2,
    CFG_EVLEN   = 2'd3
  } cfg_index_t;

  typedef struct packed {
    opcode_t                   opcode;
    logic signed [LVL_W-1:0]   level;
    logic [IDX_W-1:0]          read_index;
  } in_item_t;

  typedef struct packed {
    result_kind_t              result_kind;
    logic [OUT_CODE_W-1:0]     sample_code;
    logic                      event_done;
    logic                      trigger_seen;
    logic [IDX_W-1:0]          trigger_position;
    logic signed [PEAK_W-1:0]  peak_code;
    logic                      overflow_seen;
    logic                      underflow_seen;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/pdt_out_fifo.sv @@
`default_nettype none

module pdt_out_fifo #(
  parameter int DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pdt_pkg::out_item_t  push_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pdt_pkg::out_item_t  out_data
);
  import pdt_pkg::*;

  // depth must be a power of two so the pointers wrap on their own
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_item_t         mem_r [DEPTH];
  logic [PW-1:0]     wptr_r;
  logic [PW-1:0]     rptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rptr_r];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

endmodule

`default_nettype wire

@@ rtl/pulse_digitizer_trigger.sv @@
`default_nettype none

// pulse digitiser with trigger and pre-trigger capture window
//
// input channel (in_valid / in_stall / in_data): a sample op quantises the
// level with the offset, clamps it to the code range and stores it in the
// ring; a read op fetches a stored code relative to the last trigger
// result channel (out_valid / out_stall / out_data): exactly one result per
// transfer on the input, in order; the last sample of an event window also
// carries the event summary
// configuration (cfg_we / cfg_index / cfg_wdata): written while idle only;
// the user must keep to this, the block itself does not enforce it
// an item passes the input register, stages 1 and 2, the remainder stages,
// the read-position steps and the ring stage before the output queue
// throughput: one item per cycle unless stalled; the ring is a single memory
// accessed once per item in one stage, so reads and writes keep their order
// results wait in a 32-entry queue; in_stall rises once 32 items are
// accepted but not yet delivered, so a stalled receiver backs up into the
// input after 32 owed results and the queue can never overflow
// reset: counters, flags and running minimum cleared, registers at their
// defaults; the ring has no clearing pass and holds garbage until written
module pulse_digitizer_trigger #(
  parameter int CODE_BITS  = 14,
  parameter int RING_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pdt_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pdt_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [pdt_pkg::CFG_W-1:0]      cfg_wdata
);
  import pdt_pkg::*;

  localparam int AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int LW    = $clog2(RING_DEPTH + 1);
  localparam int SW    = LW + 1;
  localparam int WW    = IDX_W + LW;
  localparam int CW    = LVL_W - 7;          // floor(sum/256) of a 33-bit sum
  localparam int NREM  = IDX_W;              // one remainder step per index bit
  localparam int OCC_W = $clog2(OUT_FIFO_DEPTH + 1);

  localparam logic signed [CW-1:0] FULL  = CW'((1 << CODE_BITS) - 1);
  localparam logic signed [CW-1:0] PK_HI = CW'(PEAK_MAX);
  localparam logic signed [CW-1:0] PK_LO = CW'(PEAK_MIN);

  // one item in flight after the state update
  typedef struct packed {
    opcode_t                   kind;
    logic [CODE_BITS-1:0]      code;
    logic [AW-1:0]             addr;
    logic                      done;
    logic                      trig;
    logic [IDX_W-1:0]          tpos;
    logic signed [PEAK_W-1:0]  peak;
    logic                      ovf;
    logic                      udf;
    logic [IDX_W-1:0]          ra;   // last trigger, reduced mod length
    logic [IDX_W-1:0]          rb;   // read index, reduced mod length
    logic [IDX_W-1:0]          rc;   // pre-trigger, reduced mod length
  } pipe_item_t;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic signed [CFG_W-1:0] offset_r;
  logic signed [CFG_W-1:0] trigger_r;
  logic [IDX_W-1:0]        pretrig_r;
  logic [LEN_W-1:0]        evlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= OFFSET_RST;
      trigger_r <= TRIGGER_RST;
      pretrig_r <= PRETRIG_RST;
      evlen_r   <= EVLEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET:  offset_r  <= signed'(cfg_wdata);
        CFG_TRIGGER: trigger_r <= signed'(cfg_wdata);
        CFG_PRETRIG: pretrig_r <= cfg_wdata[IDX_W-1:0];
        CFG_EVLEN:   evlen_r   <= cfg_wdata[LEN_W-1:0];
      endcase
    end
  end

  // effective window length: zero acts as one, capped at the ring depth
  logic [LW-1:0] len_w;

  always_comb begin
    if (evlen_r == '0) begin
      len_w = LW'(1);
    end else if (32'(evlen_r) > RING_DEPTH) begin
      len_w = LW'(RING_DEPTH);
    end else begin
      len_w = LW'(evlen_r);
    end
  end

  // ---------------------------------------------------------------------
  // occupancy: items accepted but not yet delivered, bounded by the queue
  // ---------------------------------------------------------------------
  logic              in_acc;
  logic              out_xfer;
  logic [OCC_W-1:0]  occ_r;

  assign in_stall = (occ_r >= OCC_W'(OUT_FIFO_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_r + OCC_W'(in_acc) - OCC_W'(out_xfer);
    end
  end

  // ---------------------------------------------------------------------
  // stage 0: input register
  // ---------------------------------------------------------------------
  logic      s0_vld_r;
  in_item_t  s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_vld_r <= 1'b0;
    else        s0_vld_r <= in_acc;
  end

  always_ff @(posedge clk) begin
    if (in_acc) s0_r <= in_data;
  end

  // ---------------------------------------------------------------------
  // stage 1: offset add, floor to code, trigger compare on raw level
  // ---------------------------------------------------------------------
  logic signed [LVL_W:0]   sum_w;
  logic                    below_w;
  logic                    s1_vld_r;
  opcode_t                 s1_kind_r;
  logic signed [CW-1:0]    s1_code_r;
  logic                    s1_below_r;
  logic [IDX_W-1:0]        s1_idx_r;

  assign sum_w   = (LVL_W+1)'(s0_r.level) + (LVL_W+1)'(offset_r);
  assign below_w = (s0_r.level < LVL_W'(trigger_r));

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= s0_vld_r;
  end

  always_ff @(posedge clk) begin
    s1_kind_r  <= s0_r.opcode;
    s1_code_r  <= sum_w[LVL_W:8];   // arithmetic floor of sum/256
    s1_below_r <= below_w;
    s1_idx_r   <= s0_r.read_index;
  end

  // ---------------------------------------------------------------------
  // stage 2: per-event state update
  // ---------------------------------------------------------------------
  logic [AW-1:0]             cnt_r;
  logic                      trig_r;
  logic [IDX_W-1:0]          lt_r;
  logic signed [PEAK_W-1:0]  min_r;
  logic                      ovf_r;
  logic                      udf_r;

  logic                      over_w;
  logic                      under_w;
  logic [CODE_BITS-1:0]      clamp_w;
  logic signed [PEAK_W-1:0]  sat_w;
  logic                      chk_w;
  logic                      last_w;
  logic                      smp_w;

  logic                      trig_upd;
  logic [IDX_W-1:0]          lt_upd;
  logic signed [PEAK_W-1:0]  min_upd;
  logic                      ovf_upd;
  logic                      udf_upd;

  pipe_item_t                s2_nxt;
  pipe_item_t                s2_r;
  logic                      s2_vld_r;

  assign over_w  = (s1_code_r > FULL);
  assign under_w = s1_code_r[CW-1];
  assign clamp_w = under_w ? '0 : (over_w ? '1 : s1_code_r[CODE_BITS-1:0]);
  assign sat_w   = (s1_code_r > PK_HI) ? PEAK_MAX :
                   (s1_code_r < PK_LO) ? PEAK_MIN : s1_code_r[PEAK_W-1:0];
  assign chk_w   = (32'(cnt_r) >= 32'(pretrig_r));
  assign last_w  = ((32'(cnt_r) + 32'd1) >= 32'(len_w));
  assign smp_w   = s1_vld_r && (s1_kind_r == OP_SAMPLE);

  always_comb begin
    trig_upd = trig_r;
    lt_upd   = lt_r;
    min_upd  = min_r;
    ovf_upd  = ovf_r;
    udf_upd  = udf_r;
    if (chk_w) begin
      // only the first crossing after pre-trigger moves the trigger position
      if (s1_below_r && !trig_r) begin
        trig_upd = 1'b1;
        lt_upd   = IDX_W'(cnt_r);
      end
      if (over_w) ovf_upd = 1'b1;
      if (under_w) udf_upd = 1'b1;
      if (sat_w < min_r) min_upd = sat_w;
    end
  end

  always_comb begin
    s2_nxt      = '0;
    s2_nxt.kind = s1_kind_r;
    if (s1_kind_r == OP_READ) begin
      s2_nxt.ra = lt_r;
      s2_nxt.rb = s1_idx_r;
      s2_nxt.rc = pretrig_r;
    end else begin
      s2_nxt.code = clamp_w;
      s2_nxt.addr = cnt_r;
      if (last_w) begin
        s2_nxt.done = 1'b1;
        s2_nxt.trig = trig_upd;
        s2_nxt.tpos = lt_upd;
        s2_nxt.peak = min_upd;
        s2_nxt.ovf  = ovf_upd;
        s2_nxt.udf  = udf_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      trig_r <= 1'b0;
      lt_r   <= '0;
      min_r  <= PEAK_MAX;
      ovf_r  <= 1'b0;
      udf_r  <= 1'b0;
    end else if (smp_w) begin
      lt_r <= lt_upd;   // last trigger survives the end of an event
      if (last_w) begin
        cnt_r  <= '0;
        trig_r <= 1'b0;
        min_r  <= PEAK_MAX;
        ovf_r  <= 1'b0;
        udf_r  <= 1'b0;
      end else begin
        cnt_r  <= cnt_r + 1'b1;
        trig_r <= trig_upd;
        min_r  <= min_upd;
        ovf_r  <= ovf_upd;
        udf_r  <= udf_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

  // ---------------------------------------------------------------------
  // remainder pipeline: three lanes reduced mod length, one bit per stage
  // ---------------------------------------------------------------------
  pipe_item_t        rem_r [NREM];
  logic [NREM-1:0]   rem_vld_r;

  for (genvar k = 0; k < NREM; k++) begin : g_rem
    pipe_item_t     src;
    pipe_item_t     dst;
    logic           src_vld;
    logic [WW-1:0]  dv;

    if (k == 0) begin : g_first
      assign src     = s2_r;
      assign src_vld = s2_vld_r;
    end else begin : g_next
      assign src     = rem_r[k-1];
      assign src_vld = rem_vld_r[k-1];
    end

    assign dv = WW'(len_w) << (NREM - 1 - k);

    always_comb begin
      dst = src;
      if (WW'(src.ra) >= dv) dst.ra = src.ra - IDX_W'(dv);
      if (WW'(src.rb) >= dv) dst.rb = src.rb - IDX_W'(dv);
      if (WW'(src.rc) >= dv) dst.rc = src.rc - IDX_W'(dv);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) rem_vld_r[k] <= 1'b0;
      else        rem_vld_r[k] <= src_vld;
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= dst;
    end
  end

  // ---------------------------------------------------------------------
  // read position: (a + b + len - c) mod len in two compare-subtract steps
  // ---------------------------------------------------------------------
  pipe_item_t     q1_nxt;
  pipe_item_t     q1_r;
  logic           q1_vld_r;
  logic [SW-1:0]  sab_w;
  logic [SW-1:0]  sab_red_w;

  assign sab_w     = SW'(rem_r[NREM-1].ra) + SW'(rem_r[NREM-1].rb);
  assign sab_red_w = (sab_w >= SW'(len_w)) ? (sab_w - SW'(len_w)) : sab_w;

  always_comb begin
    q1_nxt = rem_r[NREM-1];
    if (rem_r[NREM-1].kind == OP_READ) q1_nxt.addr = AW'(sab_red_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) q1_vld_r <= 1'b0;
    else        q1_vld_r <= rem_vld_r[NREM-1];
  end

  always_ff @(posedge clk) begin
    q1_r <= q1_nxt;
  end

  pipe_item_t     q2_nxt;
  pipe_item_t     q2_r;
  logic           q2_vld_r;
  logic [SW-1:0]  pos_w;
  logic [SW-1:0]  pos_red_w;

  assign pos_w     = SW'(q1_r.addr) + SW'(len_w) - SW'(q1_r.rc);
  assign pos_red_w = (pos_w >= SW'(len_w)) ? (pos_w - SW'(len_w)) : pos_w;

  always_comb begin
    q2_nxt = q1_r;
    if (q1_r.kind == OP_READ) q2_nxt.addr = AW'(pos_red_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) q2_vld_r <= 1'b0;
    else        q2_vld_r <= q1_vld_r;
  end

  always_ff @(posedge clk) begin
    q2_r <= q2_nxt;
  end

  // ---------------------------------------------------------------------
  // sample ring: one access per item, write for samples, read for reads
  // ---------------------------------------------------------------------
  logic [CODE_BITS-1:0]  ring_mem [RING_DEPTH];
  logic [CODE_BITS-1:0]  rd_data_r;
  pipe_item_t            m_r;
  logic                  m_vld_r;

  always_ff @(posedge clk) begin
    if (q2_vld_r && (q2_r.kind == OP_SAMPLE)) ring_mem[q2_r.addr] <= q2_r.code;
    if (q2_vld_r && (q2_r.kind == OP_READ))   rd_data_r <= ring_mem[q2_r.addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m_vld_r <= 1'b0;
    else        m_vld_r <= q2_vld_r;
  end

  always_ff @(posedge clk) begin
    m_r <= q2_r;
  end

  // ---------------------------------------------------------------------
  // result assembly and output queue
  // ---------------------------------------------------------------------
  out_item_t res_w;

  always_comb begin
    res_w = '0;
    if (m_r.kind == OP_READ) begin
      res_w.result_kind = RK_READ;
      res_w.sample_code = OUT_CODE_W'(rd_data_r);
    end else begin
      res_w.result_kind      = RK_SAMPLE;
      res_w.sample_code      = OUT_CODE_W'(m_r.code);
      res_w.event_done       = m_r.done;
      res_w.trigger_seen     = m_r.trig;
      res_w.trigger_position = m_r.tpos;
      res_w.peak_code        = m_r.peak;
      res_w.overflow_seen    = m_r.ovf;
      res_w.underflow_seen   = m_r.udf;
    end
  end

  pdt_out_fifo #(
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (m_vld_r),
    .push_data (res_w),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/pdt_checker.sv @@
`default_nettype none

module pdt_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_stall,
  input  logic                out_valid,
  input  logic                out_stall,
  input  pdt_pkg::out_item_t  out_data
);
  import pdt_pkg::*;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a held result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // read results carry no event summary
  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == RK_READ) |->
      !out_data.event_done && !out_data.trigger_seen &&
      (out_data.trigger_position == '0) && (out_data.peak_code == '0) &&
      !out_data.overflow_seen && !out_data.underflow_seen)
    else $error("read result with summary fields set");

  // summary only on the last sample of an event
  a_mid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == RK_SAMPLE) && !out_data.event_done |->
      !out_data.trigger_seen && (out_data.trigger_position == '0) &&
      (out_data.peak_code == '0) && !out_data.overflow_seen &&
      !out_data.underflow_seen)
    else $error("summary fields set before the end of an event");

  // nothing outstanding after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("outstanding items after reset");

endmodule

bind pulse_digitizer_trigger pdt_checker u_pdt_checker (.*);

`default_nettype wire

@@ sim/pulse_digitizer_trigger_test.sv @@
`default_nettype none

module pulse_digitizer_trigger_test;
  import pdt_pkg::*;

  localparam int RING     = 1024;
  localparam int CODE_MAX = 16383;
  localparam int LIMIT    = 400000;
  localparam int SETTLE   = 40;
  localparam int PHASES   = 14;
  localparam int PER_PHASE = 50;

  // clock and block inputs, all at known values from time zero
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we    = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  pulse_digitizer_trigger dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // items waiting for the driver and results the block still owes us
  in_item_t  pending_items[$];
  out_item_t due_results[$];

  // shadow of the digitiser: ring, per-event state and registers
  logic [OUT_CODE_W-1:0] code_ring [RING];
  bit                    ring_filled [RING];
  int unsigned           win_pos   = 0;
  bit                    trig_hit  = 1'b0;
  logic [IDX_W-1:0]      trig_at   = '0;
  int                    min_code  = 8388607;
  bit                    over_hit  = 1'b0;
  bit                    under_hit = 1'b0;
  int                    offset_q  = OFFSET_RST;
  int                    trigger_q = TRIGGER_RST;
  int unsigned           pretrig_q = PRETRIG_RST;
  int unsigned           evlen_q   = EVLEN_RST;

  // run bookkeeping
  bit          quiet = 1'b0;
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          events_seen = 0;
  int          triggers_seen = 0;
  int          reads_seen = 0;
  int          cycles = 0;
  int          stall_left = 0;
  out_item_t   want;
  string       diffs;

  // window length as the block applies it: zero acts as one, cap at ring depth
  function automatic int unsigned win_len();
    if (evlen_q == 0) return 1;
    if (evlen_q > RING) return RING;
    return evlen_q;
  endfunction

  // expected result of one item, advancing the shadow state
  function automatic out_item_t digitise(in_item_t it);
    int unsigned len;
    int unsigned pos;
    longint      code;
    longint      sat;
    logic [OUT_CODE_W-1:0] clamped;
    out_item_t   r;
    len = win_len();
    r = '0;
    if (it.opcode == OP_READ) begin
      pos = (trig_at % len + it.read_index % len + (len - pretrig_q % len)) % len;
      r.result_kind = RK_READ;
      r.sample_code = code_ring[pos];
      return r;
    end
    // arithmetic shift gives the floor of the division by 256
    code = (longint'(it.level) + longint'(offset_q)) >>> 8;
    if (code < 0) clamped = '0;
    else if (code > CODE_MAX) clamped = OUT_CODE_W'(CODE_MAX);
    else clamped = code[OUT_CODE_W-1:0];
    code_ring[win_pos] = clamped;
    ring_filled[win_pos] = 1'b1;
    if (win_pos >= pretrig_q) begin
      if (it.level < trigger_q && !trig_hit) begin
        trig_hit = 1'b1;
        trig_at = win_pos[IDX_W-1:0];
      end
      if (code > CODE_MAX) over_hit = 1'b1;
      else if (code < 0) under_hit = 1'b1;
      if (code > PEAK_MAX) sat = PEAK_MAX;
      else if (code < PEAK_MIN) sat = PEAK_MIN;
      else sat = code;
      if (sat < min_code) min_code = int'(sat);
    end
    r.result_kind = RK_SAMPLE;
    r.sample_code = clamped;
    if (win_pos + 1 >= len) begin
      // event window closes: report summary, clear per-event state
      r.event_done       = 1'b1;
      r.trigger_seen     = trig_hit;
      r.trigger_position = trig_at;
      r.peak_code        = min_code[PEAK_W-1:0];
      r.overflow_seen    = over_hit;
      r.underflow_seen   = under_hit;
      win_pos   = 0;
      trig_hit  = 1'b0;
      min_code  = 8388607;
      over_hit  = 1'b0;
      under_hit = 1'b0;
    end else begin
      win_pos = win_pos + 1;
    end
    return r;
  endfunction

  // aim a read at a ring entry already written; high index bits via multiples
  // of the window length
  function automatic bit aim_read(inout in_item_t it);
    int unsigned len;
    int unsigned start;
    int unsigned p;
    int unsigned base;
    len = win_len();
    start = $urandom_range(0, len - 1);
    for (int unsigned n = 0; n < len; n++) begin
      p = (start + n) % len;
      if (ring_filled[p]) begin
        base = (p + len - trig_at % len + pretrig_q % len) % len;
        it.read_index = IDX_W'(base + $urandom_range(0, (1023 - base) / len) * len);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // signal levels: raw noise, trigger edge, clamp edges, baseline and dips
  function automatic logic signed [LVL_W-1:0] pick_level();
    longint v;
    int     c;
    case ($urandom_range(0, 19))
      0, 1: v = $urandom;
      2, 3, 4, 5: v = longint'(trigger_q) + int'($urandom_range(0, 8)) - 4;
      6, 7, 8: begin
        case ($urandom_range(0, 3))
          0: c = -1;
          1: c = 0;
          2: c = CODE_MAX;
          default: c = CODE_MAX + 1;
        endcase
        v = longint'(c) * 256 - offset_q + int'($urandom_range(0, 255));
      end
      9, 10, 11, 12, 13, 14: begin
        c = $urandom_range(0, CODE_MAX);
        v = longint'(c) * 256 - offset_q + int'($urandom_range(0, 255));
      end
      default: v = longint'(trigger_q) - int'($urandom_range(1, 300000));
    endcase
    return v[LVL_W-1:0];
  endfunction

  function automatic string field_diffs(out_item_t w, out_item_t g);
    string s;
    s = "";
    if (g.result_kind !== w.result_kind)
      s = {s, $sformatf(" result_kind exp %0d got %0d", w.result_kind, g.result_kind)};
    if (g.sample_code !== w.sample_code)
      s = {s, $sformatf(" sample_code exp %0d got %0d", w.sample_code, g.sample_code)};
    if (g.event_done !== w.event_done)
      s = {s, $sformatf(" event_done exp %0d got %0d", w.event_done, g.event_done)};
    if (g.trigger_seen !== w.trigger_seen)
      s = {s, $sformatf(" trigger_seen exp %0d got %0d", w.trigger_seen, g.trigger_seen)};
    if (g.trigger_position !== w.trigger_position)
      s = {s, $sformatf(" trigger_position exp %0d got %0d",
                        w.trigger_position, g.trigger_position)};
    if (g.peak_code !== w.peak_code)
      s = {s, $sformatf(" peak_code exp %0d got %0d", w.peak_code, g.peak_code)};
    if (g.overflow_seen !== w.overflow_seen)
      s = {s, $sformatf(" overflow_seen exp %0d got %0d", w.overflow_seen, g.overflow_seen)};
    if (g.underflow_seen !== w.underflow_seen)
      s = {s, $sformatf(" underflow_seen exp %0d got %0d",
                        w.underflow_seen, g.underflow_seen)};
    return s;
  endfunction

  task automatic queue_item(in_item_t it);
    due_results   = {due_results, digitise(it)};
    pending_items = {pending_items, it};
  endtask

  task automatic add_sample(logic signed [LVL_W-1:0] lvl);
    in_item_t it;
    it.opcode = OP_SAMPLE;
    it.level = lvl;
    it.read_index = IDX_W'($urandom);
    queue_item(it);
  endtask

  // a read where some entry is written, else a sample instead
  task automatic add_read();
    in_item_t it;
    it.opcode = OP_READ;
    it.level = $urandom;
    it.read_index = '0;
    if (!aim_read(it)) begin
      it.opcode = OP_SAMPLE;
      it.level = pick_level();
      it.read_index = IDX_W'($urandom);
    end
    queue_item(it);
  endtask

  // sender holds off until every owed result has come back
  task automatic drain();
    while (pending_items.size() != 0 || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_OFFSET:  offset_q  = int'($signed(val));
      CFG_TRIGGER: trigger_q = int'($signed(val));
      CFG_PRETRIG: pretrig_q = val[IDX_W-1:0];
      default:     evlen_q   = val[LEN_W-1:0];
    endcase
  endtask

  // new register set for a random phase, unused upper bits filled with noise
  task automatic shuffle_settings(int ph);
    logic [CFG_W-1:0] w;
    int unsigned ev;
    int unsigned eff;
    int unsigned pre;
    int          off;
    int          trg;
    case ($urandom_range(0, 4))
      0: off = -4194304;
      1: off = 4194304;
      default: off = int'($urandom_range(0, 8388608)) - 4194304;
    endcase
    case ($urandom_range(0, 5))
      0: trg = -4194304;
      1: trg = 4194304;
      default: trg = int'($urandom_range(0, 8388608)) - 4194304;
    endcase
    if (ph == 0) ev = 2047;
    else if (ph == 1) ev = $urandom_range(2, 20);
    else begin
      case ($urandom_range(0, 9))
        0: ev = 0;
        1: ev = 1;
        2: ev = $urandom_range(0, 1) ? 1024 : 2047;
        default: ev = $urandom_range(2, 40);
      endcase
    end
    eff = (ev == 0) ? 1 : (ev > RING) ? RING : ev;
    if (ph == 0) pre = 1023;
    else begin
      case ($urandom_range(0, 9))
        0: pre = 0;
        1: pre = 1023;
        2: pre = (eff <= 1023) ? $urandom_range(eff, 1023) : 0;
        default: pre = $urandom_range(0, eff - 1);
      endcase
    end
    write_reg(CFG_OFFSET, off[CFG_W-1:0]);
    write_reg(CFG_TRIGGER, trg[CFG_W-1:0]);
    w = CFG_W'($urandom);
    w[IDX_W-1:0] = pre[IDX_W-1:0];
    write_reg(CFG_PRETRIG, w);
    w = CFG_W'($urandom);
    w[LEN_W-1:0] = ev[LEN_W-1:0];
    write_reg(CFG_EVLEN, w);
  endtask

  // driver: next item once the current one has been transferred
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_items.size() != 0 && (quiet || $urandom_range(0, 99) >= 14)) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
        items_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure: short bursts plus the odd long one that fills
  // the result queue and reaches back to the input
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 999) == 0) begin
      out_stall <= 1'b1;
      stall_left = 59;
    end else if ($urandom_range(0, 99) < 2) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: each result transfer against the oldest owed result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with nothing owed at cycle %0d", cycles);
      end else begin
        want = due_results.pop_front();
        diffs = field_diffs(want, out_data);
        if (diffs != "") begin
          errors++;
          if (errors <= 10) $display("result %0d differs:%s", results_seen, diffs);
        end
        results_seen++;
        if (want.result_kind == RK_READ) reads_seen++;
        if (want.event_done) events_seen++;
        if (want.event_done && want.trigger_seen) triggers_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("run stopped after %0d cycles, %0d results still owed",
               cycles, due_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: code edges, trigger edge, full-scale extremes
    add_sample(0);
    add_sample(32'sh7FFFFFFF);
    add_sample(32'sh80000000);
    add_sample(-1);
    add_sample(-2097152);
    add_sample(-2097153);
    add_sample(-6291);
    add_sample(-6292);
    add_sample(16383 * 256 - 2097152);
    add_sample(16384 * 256 - 2097152);
    add_sample(16384 * 256 - 1 - 2097152);
    add_read();
    add_read();
    add_read();
    drain();

    // zero-length window acts as one: each sample closes an event;
    // a large negative offset drives the peak into negative saturation
    write_reg(CFG_OFFSET, 24'hC00000);
    write_reg(CFG_TRIGGER, 24'h400000);
    write_reg(CFG_PRETRIG, 24'h000000);
    write_reg(CFG_EVLEN, 24'h000000);
    add_sample(32'sh80000000);
    add_sample(32'sh7FFFFFFF);
    add_read();
    add_sample(4194304);
    add_sample(4194303);
    add_read();
    drain();

    // large positive offset with noisy upper register bits, positive saturation
    write_reg(CFG_OFFSET, 24'h400000);
    write_reg(CFG_EVLEN, 24'hFFF801);
    add_sample(32'sh7FFFFFFF);
    add_read();
    drain();

    // random phases: first a capped window that never completes, then a short
    // one so the counter may already sit past the end
    for (int ph = 0; ph < PHASES; ph++) begin
      shuffle_settings(ph);
      quiet = (ph == 6 || ph == 7);
      for (int i = 0; i < (ph == 0 ? 15 : PER_PHASE); i++) begin
        if (ph == 3 && i == PER_PHASE / 2) drain();
        if ($urandom_range(0, 4) == 0) add_read();
        else add_sample(pick_level());
      end
      drain();
    end
    quiet = 1'b0;

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("%0d items driven, %0d results checked (%0d reads)",
             items_sent, results_seen, reads_seen);
    $display("%0d event windows closed, %0d with a trigger, %0d mismatches",
             events_seen, triggers_seen, errors);
    if (errors == 0 && due_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/pdt_pkg.sv
rtl/pdt_out_fifo.sv
rtl/pulse_digitizer_trigger.sv
rtl/pdt_checker.sv
sim/pulse_digitizer_trigger_test.sv
